/* hw/rtl/wps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wps_pkg
// shared types, constants and helpers of the led strip serializer
// ----------------------------------------------------------------------------
package wps_pkg;

    localparam int MAX_PIXELS = 256;
    localparam int PIX_AW     = $clog2(MAX_PIXELS);
    localparam int NUM_W      = 9;
    localparam int WORD_W     = 24;
    localparam int BIT_CNT_W  = 5;
    localparam int PHASE_W    = 16;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [BIT_CNT_W-1:0] BITS_PER_PIXEL = BIT_CNT_W'(WORD_W);
    localparam logic [NUM_W-1:0]     PIX_LIMIT      = NUM_W'(MAX_PIXELS);

    typedef enum logic [1:0] {
        ACT_SET  = 2'd0,
        ACT_SHOW = 2'd1,
        ACT_TICK = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        COL_OFF   = 3'd0,
        COL_RED   = 3'd1,
        COL_GREEN = 3'd2,
        COL_BLUE  = 3'd3,
        COL_WHITE = 3'd4
    } color_t;

    localparam logic [1:0] REG_NUM_PIXELS  = 2'd0;
    localparam logic [1:0] REG_SHORT_TICKS = 2'd1;
    localparam logic [1:0] REG_LONG_TICKS  = 2'd2;
    localparam logic [1:0] REG_LATCH_TICKS = 2'd3;

    typedef struct packed {
        logic [NUM_W-1:0]   num_pixels;
        logic [NUM_W-1:0]   pix_count;
        logic [7:0]         short_ticks;
        logic [7:0]         long_ticks;
        logic [PHASE_W-1:0] latch_ticks;
    } cfg_t;

    typedef struct packed {
        action_t             act;
        logic [PIX_AW-1:0]   idx;
        logic [WORD_W-1:0]   word;
        logic                in_range;
    } op_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } res_t;

    // grb word: green 23..16, red 15..8, blue 7..0
    function automatic logic [WORD_W-1:0] color_word(input logic [2:0] code);
        logic [WORD_W-1:0] w;
        begin
            case (code)
                COL_RED:   w = 24'h00FF00;
                COL_GREEN: w = 24'hFF0000;
                COL_BLUE:  w = 24'h0000FF;
                COL_WHITE: w = 24'hFFFFFF;
                default:   w = '0;
            endcase
            return w;
        end
    endfunction

endpackage

/* hw/rtl/ws2812_pixel_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ws2812_pixel_serializer
// single-wire led strip driver: pixel store, frame sequencer, apb registers
// ----------------------------------------------------------------------------
// a result is queued once its item leaves the item queue; both queues are registered
// throughput: one item per cycle, unless the result queue is full and not popped
// reset: pixel store reads as off at once through per-entry valid bits,
// no clearing pass; registers return to their defaults
// ----------------------------------------------------------------------------
module ws2812_pixel_serializer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   action,
    input  logic [7:0]                   pixel_index,
    input  logic [2:0]                   color_code,
    output logic                         empty,
    input  logic                         pop,
    output logic                         line_level,
    output logic                         busy_res,
    output logic                         frame_done,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wps_pkg::ADDR_W-1:0]   paddr,
    input  logic [wps_pkg::DATA_W-1:0]   pwdata,
    output logic [wps_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    wps_pkg::cfg_t cfg;
    wps_pkg::op_t  op;
    wps_pkg::res_t res;
    logic          op_valid;
    logic          op_pop;

    wps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .pixel_index (pixel_index),
        .color_code  (color_code),
        .cfg         (cfg),
        .op_valid    (op_valid),
        .op          (op),
        .op_pop      (op_pop)
    );

    wps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop),
        .empty    (empty),
        .pop      (pop),
        .res      (res)
    );

    assign line_level = res.line_level;
    assign busy_res   = res.busy_res;
    assign frame_done = res.frame_done;

endmodule

/* hw/rtl/wps_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wps_cfg
// apb register file for pixel count and waveform timing
// ----------------------------------------------------------------------------
module wps_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wps_pkg::ADDR_W-1:0]   paddr,
    input  logic [wps_pkg::DATA_W-1:0]   pwdata,
    output logic [wps_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output wps_pkg::cfg_t                cfg
);

    logic [wps_pkg::NUM_W-1:0]   num_pixels_reg;
    logic [7:0]                  short_ticks_reg;
    logic [7:0]                  long_ticks_reg;
    logic [wps_pkg::PHASE_W-1:0] latch_ticks_reg;
    logic                        wr_en;
    logic [1:0]                  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_pixels_reg  <= wps_pkg::NUM_W'(256);
            short_ticks_reg <= 8'd25;
            long_ticks_reg  <= 8'd50;
            latch_ticks_reg <= 16'd25000;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                wps_pkg::REG_NUM_PIXELS:  num_pixels_reg  <= pwdata[wps_pkg::NUM_W-1:0];
                wps_pkg::REG_SHORT_TICKS: short_ticks_reg <= pwdata[7:0];
                wps_pkg::REG_LONG_TICKS:  long_ticks_reg  <= pwdata[7:0];
                wps_pkg::REG_LATCH_TICKS: latch_ticks_reg <= pwdata[wps_pkg::PHASE_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            wps_pkg::REG_NUM_PIXELS:  prdata = wps_pkg::DATA_W'(num_pixels_reg);
            wps_pkg::REG_SHORT_TICKS: prdata = wps_pkg::DATA_W'(short_ticks_reg);
            wps_pkg::REG_LONG_TICKS:  prdata = wps_pkg::DATA_W'(long_ticks_reg);
            wps_pkg::REG_LATCH_TICKS: prdata = wps_pkg::DATA_W'(latch_ticks_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.num_pixels  = num_pixels_reg;
        // pixel count saturates at the store depth
        cfg.pix_count   = (num_pixels_reg > wps_pkg::PIX_LIMIT) ? wps_pkg::PIX_LIMIT
                                                                : num_pixels_reg;
        cfg.short_ticks = short_ticks_reg;
        cfg.long_ticks  = long_ticks_reg;
        cfg.latch_ticks = latch_ticks_reg;
    end

endmodule

/* hw/rtl/wps_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wps_front
// accepts items, decodes them and queues them for the waveform engine
// ----------------------------------------------------------------------------
module wps_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   action,
    input  logic [wps_pkg::PIX_AW-1:0]   pixel_index,
    input  logic [2:0]                   color_code,
    input  wps_pkg::cfg_t                cfg,
    output logic                         op_valid,
    output wps_pkg::op_t                 op,
    input  logic                         op_pop
);

    wps_pkg::op_t op_mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         push_ok;
    logic         pop_ok;
    wps_pkg::op_t dec_op;

    assign full     = (count_reg == 2'd2);
    assign op_valid = (count_reg != 2'd0);
    assign push_ok  = push && !full;
    assign pop_ok   = op_pop && op_valid;
    assign op       = op_mem_reg[rd_ptr_reg];

    always_comb
    begin
        dec_op.act      = wps_pkg::action_t'(action);
        dec_op.idx      = pixel_index;
        dec_op.word     = wps_pkg::color_word(color_code);
        dec_op.in_range = ({1'b0, pixel_index} < cfg.pix_count);
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            op_mem_reg[wr_ptr_reg] <= dec_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push_ok, pop_ok})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* hw/rtl/wps_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wps_back
// pixel store, bit waveform engine and result queue
// ----------------------------------------------------------------------------
module wps_back (
    input  logic          clk,
    input  logic          rst_n,
    input  wps_pkg::cfg_t cfg,
    input  logic          op_valid,
    input  wps_pkg::op_t  op,
    output logic          op_pop,
    output logic          empty,
    input  logic          pop,
    output wps_pkg::res_t res
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } phase_t;

    logic [wps_pkg::WORD_W-1:0]    pixel_store [wps_pkg::MAX_PIXELS];
    logic [wps_pkg::MAX_PIXELS-1:0] store_valid_reg;
    logic [wps_pkg::WORD_W-1:0]    rd_data_reg;
    logic                          rd_valid_reg;
    logic [wps_pkg::PIX_AW-1:0]    rd_addr;
    logic [wps_pkg::WORD_W-1:0]    next_word;

    phase_t                        phase_reg, phase_next;
    logic [wps_pkg::PHASE_W-1:0]   phase_count_reg, phase_count_next;
    logic [wps_pkg::BIT_CNT_W-1:0] bit_cursor_reg, bit_cursor_next;
    logic [wps_pkg::WORD_W-1:0]    shift_word_reg, shift_word_next;
    logic [wps_pkg::PIX_AW-1:0]    pixel_cursor_reg, pixel_cursor_next;
    logic [wps_pkg::WORD_W-1:0]    pix0_reg;

    wps_pkg::res_t                 res_mem_reg [2];
    logic                          res_wr_ptr_reg;
    logic                          res_rd_ptr_reg;
    logic [1:0]                    res_count_reg;
    logic                          res_pop_ok;

    logic                          exec;
    logic                          store_wr;
    logic [wps_pkg::PHASE_W-1:0]   cnt_inc;
    logic [wps_pkg::PHASE_W-1:0]   high_len;
    logic [wps_pkg::PHASE_W-1:0]   low_len;
    logic [wps_pkg::BIT_CNT_W-1:0] bit_inc;
    logic [wps_pkg::NUM_W-1:0]     cursor_inc;
    logic                          done;
    wps_pkg::res_t                 new_res;

    assign op_pop     = op_valid && (res_count_reg != 2'd2);
    assign exec       = op_pop;
    assign empty      = (res_count_reg == 2'd0);
    assign res_pop_ok = pop && !empty;
    assign res        = res_mem_reg[res_rd_ptr_reg];

    assign store_wr = exec && (op.act == wps_pkg::ACT_SET) && (phase_reg == PH_IDLE)
                      && op.in_range;

    // prefetch of the pixel after the one being sent
    assign rd_addr   = pixel_cursor_reg + wps_pkg::PIX_AW'(1);
    assign next_word = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            pixel_store[op.idx] <= op.word;
        end
        rd_data_reg <= pixel_store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            pix0_reg        <= '0;
        end
        else
        begin
            if (store_wr)
            begin
                store_valid_reg[op.idx] <= 1'b1;
                if (op.idx == '0)
                begin
                    pix0_reg <= op.word;
                end
            end
            rd_valid_reg <= store_valid_reg[rd_addr];
        end
    end

    assign cnt_inc    = phase_count_reg + wps_pkg::PHASE_W'(1);
    assign high_len   = shift_word_reg[wps_pkg::WORD_W-1] ? wps_pkg::PHASE_W'(cfg.long_ticks)
                                                          : wps_pkg::PHASE_W'(cfg.short_ticks);
    assign low_len    = shift_word_reg[wps_pkg::WORD_W-1] ? wps_pkg::PHASE_W'(cfg.short_ticks)
                                                          : wps_pkg::PHASE_W'(cfg.long_ticks);
    assign bit_inc    = bit_cursor_reg + wps_pkg::BIT_CNT_W'(1);
    assign cursor_inc = wps_pkg::NUM_W'(pixel_cursor_reg) + wps_pkg::NUM_W'(1);

    always_comb
    begin
        phase_next        = phase_reg;
        phase_count_next  = phase_count_reg;
        bit_cursor_next   = bit_cursor_reg;
        shift_word_next   = shift_word_reg;
        pixel_cursor_next = pixel_cursor_reg;
        done              = 1'b0;
        case (op.act)
            wps_pkg::ACT_SHOW:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_count_next = '0;
                    if (cfg.pix_count == '0)
                    begin
                        phase_next = PH_LATCH;
                    end
                    else
                    begin
                        phase_next        = PH_HIGH;
                        pixel_cursor_next = '0;
                        bit_cursor_next   = '0;
                        shift_word_next   = pix0_reg;
                    end
                end
            end
            wps_pkg::ACT_TICK:
            begin
                phase_count_next = cnt_inc;
                case (phase_reg)
                    PH_HIGH:
                    begin
                        if (cnt_inc >= high_len)
                        begin
                            phase_next       = PH_LOW;
                            phase_count_next = '0;
                        end
                    end
                    PH_LOW:
                    begin
                        if (cnt_inc >= low_len)
                        begin
                            phase_count_next = '0;
                            bit_cursor_next  = bit_inc;
                            shift_word_next  = {shift_word_reg[wps_pkg::WORD_W-2:0], 1'b0};
                            if (bit_inc >= wps_pkg::BITS_PER_PIXEL)
                            begin
                                bit_cursor_next = '0;
                                if (cursor_inc >= cfg.pix_count)
                                begin
                                    phase_next = PH_LATCH;
                                end
                                else
                                begin
                                    phase_next        = PH_HIGH;
                                    pixel_cursor_next = cursor_inc[wps_pkg::PIX_AW-1:0];
                                    shift_word_next   = next_word;
                                end
                            end
                            else
                            begin
                                phase_next = PH_HIGH;
                            end
                        end
                    end
                    PH_LATCH:
                    begin
                        if (cnt_inc >= cfg.latch_ticks)
                        begin
                            phase_next       = PH_IDLE;
                            phase_count_next = '0;
                            done             = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_count_next = '0;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        new_res.line_level = (phase_reg == PH_HIGH);
        new_res.busy_res   = (phase_next != PH_IDLE);
        new_res.frame_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            phase_count_reg  <= '0;
            bit_cursor_reg   <= '0;
            shift_word_reg   <= '0;
            pixel_cursor_reg <= '0;
        end
        else if (exec)
        begin
            phase_reg        <= phase_next;
            phase_count_reg  <= phase_count_next;
            bit_cursor_reg   <= bit_cursor_next;
            shift_word_reg   <= shift_word_next;
            pixel_cursor_reg <= pixel_cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_mem_reg[res_wr_ptr_reg] <= new_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_count_reg  <= 2'd0;
        end
        else
        begin
            if (exec)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
            end
            if (res_pop_ok)
            begin
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            end
            case ({exec, res_pop_ok})
                2'b10:   res_count_reg <= res_count_reg + 2'd1;
                2'b01:   res_count_reg <= res_count_reg - 2'd1;
                default: res_count_reg <= res_count_reg;
            endcase
        end
    end

endmodule

/* test/ws2812_pixel_serializer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ws2812_pixel_serializer_tb
// self-checking bench for the single-wire led strip serializer
// ----------------------------------------------------------------------------
// a grb frame predictor runs beside the block: every accepted item is played
// into it and the line level, busy flag and frame-done flag it produces are
// queued, then compared with each result popped from the block. registers
// are reprogrammed over the apb port only with no frame running and no
// result outstanding. stimulus covers the idle and busy corner cases,
// oversized and zero pixel counts, zero phase lengths, random frames under
// three idling mixes, and a long receiver stall.
// ----------------------------------------------------------------------------

typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_HIGH,
    SEQ_LOW,
    SEQ_LATCH
} seq_state_t;

class led_frame_model;
    logic [23:0]           store [256];
    int unsigned           pix_cur;
    int unsigned           bit_cur;
    logic [23:0]           shift_word;
    seq_state_t            seq;
    logic [15:0]           tick_cnt;
    logic [8:0]            npix;
    logic [7:0]            short_len;
    logic [7:0]            long_len;
    logic [15:0]           latch_len;
    wps_pkg::res_t         expected_q [$];
    int unsigned           errors;
    int unsigned           checked;
    int unsigned           frames;
    int unsigned           pixels_set;

    function new();
        foreach (store[i]) store[i] = '0;
        pix_cur    = 0;
        bit_cur    = 0;
        shift_word = '0;
        seq        = SEQ_IDLE;
        tick_cnt   = '0;
        npix       = 9'd256;
        short_len  = 8'd25;
        long_len   = 8'd50;
        latch_len  = 16'd25000;
        errors     = 0;
        checked    = 0;
        frames     = 0;
        pixels_set = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
        case (idx)
            wps_pkg::REG_NUM_PIXELS:  npix      = value[8:0];
            wps_pkg::REG_SHORT_TICKS: short_len = value[7:0];
            wps_pkg::REG_LONG_TICKS:  long_len  = value[7:0];
            wps_pkg::REG_LATCH_TICKS: latch_len = value[15:0];
            default: ;
        endcase
    endfunction

    function int unsigned pix_count();
        return (npix > 9'd256) ? 256 : int'(npix);
    endfunction

    function bit frame_active();
        return seq != SEQ_IDLE;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function logic [23:0] grb_of(logic [2:0] col);
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] b;
        g = 8'h00;
        r = 8'h00;
        b = 8'h00;
        case (col)
            wps_pkg::COL_RED:   r = 8'hFF;
            wps_pkg::COL_GREEN: g = 8'hFF;
            wps_pkg::COL_BLUE:  b = 8'hFF;
            wps_pkg::COL_WHITE: begin g = 8'hFF; r = 8'hFF; b = 8'hFF; end
            default: ;
        endcase
        return {g, r, b};
    endfunction

    function void start_pixel(int unsigned p);
        pix_cur    = p;
        bit_cur    = 0;
        shift_word = store[p % 256];
        seq        = SEQ_HIGH;
        tick_cnt   = '0;
    endfunction

    function void note_item(wps_pkg::action_t act, logic [7:0] idx, logic [2:0] col);
        wps_pkg::res_t r;
        int unsigned   count;
        logic [7:0]    hi_len;
        logic [7:0]    lo_len;
        count = pix_count();
        r.line_level = (seq == SEQ_HIGH);
        r.frame_done = 1'b0;
        hi_len = shift_word[23] ? long_len : short_len;
        lo_len = shift_word[23] ? short_len : long_len;
        case (act)
            wps_pkg::ACT_SET: begin
                if (seq == SEQ_IDLE && idx < count) begin
                    store[idx] = grb_of(col);
                    pixels_set++;
                end
            end
            wps_pkg::ACT_SHOW: begin
                if (seq == SEQ_IDLE) begin
                    if (count == 0) begin
                        seq      = SEQ_LATCH;
                        tick_cnt = '0;
                    end
                    else start_pixel(0);
                end
            end
            wps_pkg::ACT_TICK: begin
                tick_cnt = tick_cnt + 16'd1;
                case (seq)
                    SEQ_HIGH: begin
                        if (tick_cnt >= {8'h00, hi_len}) begin
                            seq      = SEQ_LOW;
                            tick_cnt = '0;
                        end
                    end
                    SEQ_LOW: begin
                        if (tick_cnt >= {8'h00, lo_len}) begin
                            tick_cnt   = '0;
                            bit_cur++;
                            shift_word = shift_word << 1;
                            if (bit_cur >= 24) begin
                                if (pix_cur + 1 >= count) begin
                                    seq     = SEQ_LATCH;
                                    bit_cur = 0;
                                end
                                else start_pixel(pix_cur + 1);
                            end
                            else seq = SEQ_HIGH;
                        end
                    end
                    SEQ_LATCH: begin
                        if (tick_cnt >= latch_len) begin
                            seq          = SEQ_IDLE;
                            tick_cnt     = '0;
                            r.frame_done = 1'b1;
                            frames++;
                        end
                    end
                    default: tick_cnt = '0;
                endcase
            end
            default: ;
        endcase
        r.busy_res = (seq != SEQ_IDLE);
        expected_q.push_back(r);
    endfunction

    function void check_result(logic lvl, logic bsy, logic done);
        wps_pkg::res_t exp_r;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 50)
                $display("%0t: result with nothing expected, got level %0b busy %0b done %0b",
                         $time, lvl, bsy, done);
            return;
        end
        exp_r = expected_q.pop_front();
        checked++;
        if (lvl !== exp_r.line_level) begin
            errors++;
            if (errors <= 50)
                $display("%0t: line_level expected %0b got %0b", $time, exp_r.line_level, lvl);
        end
        if (bsy !== exp_r.busy_res) begin
            errors++;
            if (errors <= 50)
                $display("%0t: busy_res expected %0b got %0b", $time, exp_r.busy_res, bsy);
        end
        if (done !== exp_r.frame_done) begin
            errors++;
            if (errors <= 50)
                $display("%0t: frame_done expected %0b got %0b", $time, exp_r.frame_done, done);
        end
    endfunction
endclass

module ws2812_pixel_serializer_tb;

    localparam logic [2:0] COL_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] COL_UNKNOWN_HI = 3'd7;

    logic                        clk;
    logic                        rst_n;
    logic                        push;
    logic                        full;
    logic [1:0]                  action;
    logic [7:0]                  pixel_index;
    logic [2:0]                  color_code;
    logic                        empty;
    logic                        pop;
    logic                        line_level;
    logic                        busy_res;
    logic                        frame_done;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [wps_pkg::ADDR_W-1:0]  paddr;
    logic [wps_pkg::DATA_W-1:0]  pwdata;
    logic [wps_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    led_frame_model frame_model = new();

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_req;
    int unsigned hold_left;
    int unsigned items_sent;
    int unsigned reg_writes;

    ws2812_pixel_serializer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .pixel_index (pixel_index),
        .color_code  (color_code),
        .empty       (empty),
        .pop         (pop),
        .line_level  (line_level),
        .busy_res    (busy_res),
        .frame_done  (frame_done),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("[ws2812_pixel_serializer] ERROR");
        $finish;
    end

    // result side
    initial
    begin
        pop <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                frame_model.check_result(line_level, busy_res, frame_done);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send(wps_pkg::action_t act, logic [7:0] idx, logic [2:0] col);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        action      <= act;
        pixel_index <= idx;
        color_code  <= col;
        @(posedge clk);
        while (full) @(posedge clk);
        frame_model.note_item(act, idx, col);
        items_sent++;
    endtask

    task automatic finish_frame();
        while (frame_model.frame_active())
            send(wps_pkg::ACT_TICK, 8'($urandom), 3'($urandom));
    endtask

    task automatic wait_results_drained();
        push <= 1'b0;
        while (frame_model.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] reg_idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= wps_pkg::ADDR_W'({reg_idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        frame_model.set_reg(reg_idx, value);
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits carry junk that the registers must drop
    task automatic write_config(logic [8:0] np, logic [7:0] sl, logic [7:0] ll,
                                logic [15:0] lt);
        logic [31:0] d;
        finish_frame();
        wait_results_drained();
        d = $urandom; d[8:0]  = np; write_reg(wps_pkg::REG_NUM_PIXELS, d);
        d = $urandom; d[7:0]  = sl; write_reg(wps_pkg::REG_SHORT_TICKS, d);
        d = $urandom; d[7:0]  = ll; write_reg(wps_pkg::REG_LONG_TICKS, d);
        d = $urandom; d[15:0] = lt; write_reg(wps_pkg::REG_LATCH_TICKS, d);
    endtask

    task automatic random_frames(int unsigned target);
        int unsigned start_cnt;
        int unsigned r;
        int unsigned count;
        logic [7:0]  idx;
        start_cnt = items_sent;
        while (items_sent - start_cnt < target)
        begin
            r = $urandom_range(99);
            count = frame_model.pix_count();
            if (frame_model.frame_active())
            begin
                if (r < 88)
                    send(wps_pkg::ACT_TICK, 8'($urandom), 3'($urandom));
                else if (r < 92)
                    send(wps_pkg::ACT_SET, 8'($urandom), 3'($urandom));
                else if (r < 96)
                    send(wps_pkg::ACT_SHOW, 8'($urandom), 3'($urandom));
                else
                    send(wps_pkg::ACT_NONE, 8'($urandom), 3'($urandom));
            end
            else
            begin
                if (r < 45)
                begin
                    idx = (count != 0) ? 8'($urandom_range(count - 1)) : 8'($urandom);
                    send(wps_pkg::ACT_SET, idx, 3'($urandom));
                end
                else if (r < 65)
                    send(wps_pkg::ACT_SHOW, 8'($urandom), 3'($urandom));
                else if (r < 75)
                    send(wps_pkg::ACT_TICK, 8'($urandom), 3'($urandom));
                else if (r < 80)
                    send(wps_pkg::ACT_NONE, 8'($urandom), 3'($urandom));
                else
                    send(wps_pkg::ACT_SET, 8'($urandom), 3'($urandom));
            end
        end
    endtask

    initial
    begin
        logic [8:0] np;
        rst_n       <= 1'b0;
        push        <= 1'b0;
        action      <= wps_pkg::ACT_NONE;
        pixel_index <= '0;
        color_code  <= wps_pkg::COL_OFF;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        hold_req      = 0;
        items_sent    = 0;
        reg_writes    = 0;
        send_idle_pct = 11;
        recv_idle_pct = 51;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: idle tick, no-op, stores across the full 256 range
        send(wps_pkg::ACT_TICK, 8'd0, wps_pkg::COL_OFF);
        send(wps_pkg::ACT_NONE, 8'hFF, COL_UNKNOWN_HI);
        send(wps_pkg::ACT_SET, 8'd0, wps_pkg::COL_RED);
        send(wps_pkg::ACT_SET, 8'd255, wps_pkg::COL_WHITE);
        send(wps_pkg::ACT_SET, 8'd128, wps_pkg::COL_GREEN);
        send(wps_pkg::ACT_SET, 8'd1, wps_pkg::COL_BLUE);
        send(wps_pkg::ACT_SET, 8'd2, wps_pkg::COL_OFF);
        send(wps_pkg::ACT_SET, 8'd3, COL_UNKNOWN_HI);

        // zero phase lengths, out of range index, requests while busy,
        // long receiver stall while the frame is ticked
        write_config(9'd3, 8'd0, 8'd1, 16'd0);
        send(wps_pkg::ACT_SET, 8'd3, wps_pkg::COL_WHITE);
        send(wps_pkg::ACT_SET, 8'd2, COL_UNKNOWN_LO);
        send(wps_pkg::ACT_SHOW, 8'd0, wps_pkg::COL_OFF);
        send(wps_pkg::ACT_SHOW, 8'd0, wps_pkg::COL_OFF);
        send(wps_pkg::ACT_SET, 8'd0, wps_pkg::COL_GREEN);
        send(wps_pkg::ACT_NONE, 8'd0, wps_pkg::COL_OFF);
        hold_req = 500;
        finish_frame();

        // empty frame goes straight to the latch
        write_config(9'd0, 8'd2, 8'd3, 16'd2);
        send(wps_pkg::ACT_SET, 8'd0, wps_pkg::COL_WHITE);
        send(wps_pkg::ACT_SHOW, 8'd0, wps_pkg::COL_OFF);
        finish_frame();

        // oversized pixel count accepts stores up to the top of the store
        write_config(9'h1FF, 8'd0, 8'd0, 16'd1);
        send(wps_pkg::ACT_SET, 8'd255, wps_pkg::COL_WHITE);
        send(wps_pkg::ACT_SET, 8'd200, wps_pkg::COL_BLUE);
        send(wps_pkg::ACT_SET, 8'd17, wps_pkg::COL_RED);
        send(wps_pkg::ACT_TICK, 8'd0, wps_pkg::COL_OFF);

        for (int p = 0; p < 6; p++)
        begin
            if (p == 2)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 11;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            np = ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom_range(1, 4));
            write_config(np, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 4)),
                         16'($urandom_range(0, 40)));
            random_frames(170);
        end

        finish_frame();
        wait_results_drained();
        repeat (10) @(posedge clk);
        $display("run covered %0d items, %0d frames, %0d pixel writes, %0d register writes",
                 items_sent, frame_model.frames, frame_model.pixels_set, reg_writes);
        $display("%0d results compared, %0d mismatches", frame_model.checked,
                 frame_model.errors);
        if (frame_model.errors == 0 && frame_model.pending() == 0)
            $display("[ws2812_pixel_serializer] OK");
        else
            $display("[ws2812_pixel_serializer] ERROR");
        $finish;
    end

endmodule
